### rtl/assert_macros.svh
// Concurrent assertion helpers. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/h36fd_pkg.sv
package h36fd_pkg;

  localparam logic [2:0] MAX_WIDTH = 3'd5;
  localparam logic [2:0] FIELD_WIDTH_RESET = 3'd5;
  localparam logic REG_FIELD_WIDTH = 1'b0;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
  localparam logic [1:0] ST_LONE_SIGN = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DEC,
    PH_DEC_END,
    PH_HY,
    PH_HY_TRAIL
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [26:0] acc;
    logic        neg;
    logic        lower;
    logic [2:0]  count;
    logic [1:0]  err;
  } field_state_t;

  localparam field_state_t FIELD_CLEAR = '{
    phase: PH_LEAD, acc: 27'd0, neg: 1'b0, lower: 1'b0, count: 3'd0, err: ST_OK
  };

  // Offset added to the base-36 magnitude of a hybrid field of width w.
  function automatic logic signed [27:0] hybrid_offset(input logic lower,
                                                       input logic [2:0] w);
    logic signed [27:0] off;
    case (w)
      3'd1: off = lower ? 28'sd26 : 28'sd0;
      3'd2: off = lower ? 28'sd676 : -28'sd260;
      3'd3: off = lower ? 28'sd21736 : -28'sd11960;
      3'd4: off = lower ? 28'sd756496 : -28'sd456560;
      default: off = lower ? 28'sd26973856 : -28'sd16696160;
    endcase
    return off;
  endfunction

endpackage

### rtl/h36fd_if.sv
interface h36fd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

interface h36fd_result_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] number;
  logic [1:0]         status;
  modport source(output valid, number, status, input ready);
  modport sink(input valid, number, status, output ready);
endinterface

### rtl/h36fd_char_step.sv
module h36fd_char_step (
  input  logic [7:0]              char_code,
  input  h36fd_pkg::field_state_t cur,
  output h36fd_pkg::field_state_t nxt
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic        blank;
  logic        digit;
  logic        sign;
  logic        lower_ch;
  logic        upper_ch;
  logic [3:0]  dig_val;
  logic [2:0]  cnt;
  logic        upd;
  logic        hy_lower;
  logic        hy_ok;
  logic [5:0]  hy_val;
  logic [26:0] acc_dec;
  logic [26:0] acc_hy;

  always_comb begin
    blank    = char_code inside {8'h20, 8'h09, 8'h0D, 8'h0A};
    digit    = char_code inside {[8'h30:8'h39]};
    sign     = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    lower_ch = char_code inside {[8'h61:8'h7A]};
    upper_ch = char_code inside {[8'h41:8'h5A]};
    dig_val  = 4'(char_code - CH_ZERO);
    cnt      = (cur.count == 3'd7) ? 3'd7 : cur.count + 3'd1;
    upd      = cnt <= h36fd_pkg::MAX_WIDTH;
    hy_lower = (cur.phase == h36fd_pkg::PH_LEAD) ? lower_ch : cur.lower;

    hy_ok  = 1'b1;
    hy_val = {2'b00, dig_val};
    if (!digit) begin
      if (hy_lower && lower_ch) begin
        hy_val = 6'(char_code - CH_LOWER_A + 8'd10);
      end else if (!hy_lower && upper_ch) begin
        hy_val = 6'(char_code - CH_UPPER_A + 8'd10);
      end else begin
        hy_ok = 1'b0;
      end
    end

    acc_dec = 27'(cur.acc * 27'd10 + 27'(dig_val));
    acc_hy  = 27'(cur.acc * 27'd36 + 27'(hy_val));

    nxt       = cur;
    nxt.count = cnt;
    case (cur.phase)
      h36fd_pkg::PH_LEAD: begin
        if (!blank) begin
          if (sign) begin
            nxt.neg   = (char_code == CH_MINUS);
            nxt.phase = h36fd_pkg::PH_SIGN;
          end else if (digit) begin
            nxt.acc   = 27'(dig_val);
            nxt.phase = h36fd_pkg::PH_DEC;
          end else begin
            nxt.lower = lower_ch;
            nxt.phase = h36fd_pkg::PH_HY;
            if (!hy_ok) begin
              if (cur.err == h36fd_pkg::ST_OK) begin
                nxt.err = h36fd_pkg::ST_BAD_CHAR;
              end
            end else if (upd) begin
              nxt.acc = acc_hy;
            end
          end
        end
      end
      h36fd_pkg::PH_SIGN: begin
        if (digit) begin
          nxt.acc   = 27'(dig_val);
          nxt.phase = h36fd_pkg::PH_DEC;
        end else begin
          if (cur.err == h36fd_pkg::ST_OK) begin
            nxt.err = h36fd_pkg::ST_LONE_SIGN;
          end
          nxt.phase = h36fd_pkg::PH_DEC_END;
        end
      end
      h36fd_pkg::PH_DEC: begin
        if (digit) begin
          if (upd) begin
            nxt.acc = acc_dec;
          end
        end else begin
          nxt.phase = h36fd_pkg::PH_DEC_END;
        end
      end
      h36fd_pkg::PH_HY: begin
        if (blank) begin
          nxt.phase = h36fd_pkg::PH_HY_TRAIL;
        end else if (!hy_ok) begin
          if (cur.err == h36fd_pkg::ST_OK) begin
            nxt.err = h36fd_pkg::ST_BAD_CHAR;
          end
        end else if (upd) begin
          nxt.acc = acc_hy;
        end
      end
      h36fd_pkg::PH_HY_TRAIL: begin
        if (!blank) begin
          if (cur.err == h36fd_pkg::ST_OK) begin
            nxt.err = h36fd_pkg::ST_BAD_CHAR;
          end
          nxt.phase = h36fd_pkg::PH_HY;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/hybrid36_field_decoder_unit.sv
// Decodes one fixed-width numeric text field into a signed integer.
// Characters arrive on in_if, one per request, leftmost first; last_char
// marks the final character of the field. Blanks are trimmed at both ends;
// a field opening with a sign or digit is decimal, otherwise hybrid-36.
// One result per field leaves on out_if: number, and status (ok, bad
// hybrid-36 character, sign without digits, field too long).
// A character is taken every cycle except while a last character waits on
// a stalled out_if. Each request passes an input register, a one-character
// decode step and a finishing stage; results wait in an output register.
// When out_if stalls, the finished result and one pending field result are
// held while further non-final characters keep being accepted; in_if.ready
// falls only once a last character can no longer be placed.
// The APB port holds field_width (paddr[2] = 0), read back on prdata.
// Reset clears the pipeline valid flags and the partial field, and sets
// field_width to 5; it must only be written while the block is idle.
`include "assert_macros.svh"

module hybrid36_field_decoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  h36fd_char_if.sink            in_if,
  h36fd_result_if.source        out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic                    in_valid_r, in_valid_nxt;
  logic [7:0]              in_char_r;
  logic                    in_last_r;
  h36fd_pkg::field_state_t st_r, st_nxt, st_step;
  logic                    fin_valid_r, fin_valid_nxt;
  h36fd_pkg::field_state_t fin_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [27:0]      out_number_r, out_number_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [2:0]              field_width_r, field_width_nxt;

  logic                    out_free;
  logic                    fin_free;
  logic                    in_go;
  logic                    in_take;
  logic                    cfg_write;
  logic [2:0]              w_eff;
  logic [1:0]              err_end;
  logic signed [27:0]      dec_num;
  logic signed [27:0]      hy_num;

  h36fd_char_step u_step (
    .char_code (in_char_r),
    .cur       (st_r),
    .nxt       (st_step)
  );

  always_comb begin
    out_free = !out_valid_r || out_if.ready;
    fin_free = !fin_valid_r || out_free;
    in_go    = in_valid_r && (!in_last_r || fin_free);
    in_take  = !in_valid_r || in_go;

    in_valid_nxt = in_take ? in_if.valid : in_valid_r;

    st_nxt = st_r;
    if (in_go) begin
      st_nxt = in_last_r ? h36fd_pkg::FIELD_CLEAR : st_step;
    end

    fin_valid_nxt = fin_free ? (in_go && in_last_r) : fin_valid_r;

    if (field_width_r == 3'd0) begin
      w_eff = 3'd1;
    end else if (field_width_r > h36fd_pkg::MAX_WIDTH) begin
      w_eff = h36fd_pkg::MAX_WIDTH;
    end else begin
      w_eff = field_width_r;
    end

    err_end = fin_r.err;
    if (fin_r.phase == h36fd_pkg::PH_SIGN && fin_r.err == h36fd_pkg::ST_OK) begin
      err_end = h36fd_pkg::ST_LONE_SIGN;
    end

    dec_num = fin_r.neg ? -$signed({1'b0, fin_r.acc}) : $signed({1'b0, fin_r.acc});
    hy_num  = $signed({1'b0, fin_r.acc}) + h36fd_pkg::hybrid_offset(fin_r.lower, w_eff);

    out_status_nxt = (fin_r.count > w_eff) ? h36fd_pkg::ST_TOO_LONG : err_end;
    out_number_nxt = 28'sd0;
    if (out_status_nxt == h36fd_pkg::ST_OK) begin
      case (fin_r.phase)
        h36fd_pkg::PH_DEC, h36fd_pkg::PH_DEC_END: out_number_nxt = dec_num;
        h36fd_pkg::PH_HY, h36fd_pkg::PH_HY_TRAIL: out_number_nxt = hy_num;
        default: out_number_nxt = 28'sd0;
      endcase
    end

    out_valid_nxt = out_free ? fin_valid_r : out_valid_r;

    cfg_write = cfg_psel && cfg_penable && cfg_pwrite;
    field_width_nxt = field_width_r;
    if (cfg_write && cfg_paddr[2] == h36fd_pkg::REG_FIELD_WIDTH) begin
      field_width_nxt = cfg_pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      st_r          <= h36fd_pkg::FIELD_CLEAR;
      fin_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      field_width_r <= h36fd_pkg::FIELD_WIDTH_RESET;
    end else begin
      in_valid_r    <= in_valid_nxt;
      st_r          <= st_nxt;
      fin_valid_r   <= fin_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      field_width_r <= field_width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_if.char_code;
      in_last_r <= in_if.last_char;
    end
    if (fin_free && in_go && in_last_r) begin
      fin_r <= st_step;
    end
    if (out_free && fin_valid_r) begin
      out_number_r <= out_number_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign in_if.ready   = in_take;
  assign out_if.valid  = out_valid_r;
  assign out_if.number = out_number_r;
  assign out_if.status = out_status_r;
  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = (cfg_paddr[2] == h36fd_pkg::REG_FIELD_WIDTH) ?
                         {29'd0, field_width_r} : 32'd0;

  `ASSERT_NEXT(a_fin_load, in_go && in_last_r && fin_free, fin_valid_r,
               "final character lost")
  `ASSERT_NEXT(a_field_clear, in_go && in_last_r, st_r == h36fd_pkg::FIELD_CLEAR,
               "field not cleared")
  `ASSERT_NEXT(a_fin_hold, fin_valid_r && !out_free, fin_valid_r && $stable(fin_r),
               "pending result dropped")
  `ASSERT_SAME(a_err_zero, out_valid_r && out_status_r != h36fd_pkg::ST_OK,
               out_number_r == 28'sd0, "nonzero number on error")

endmodule
